>>> rtl/ucb1_pkg.sv
package ucb1_pkg;

  typedef enum logic [2:0] {
    OP_SELECT  = 3'd0,
    OP_OBSERVE = 3'd1,
    OP_SETCNT  = 3'd2,
    OP_SETMEAN = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  localparam int CNT_W  = 24;
  localparam int MEAN_W = 32;
  localparam int NUM_W  = 41;
  localparam int SQ_W   = 42;
  localparam int LN_W   = 21;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 24'hFFFFFF;
  localparam logic [31:0]      TOTAL_MAX   = 32'hFFFFFFFF;
  localparam logic [31:0]      LN2_Q32     = 32'd2977044472;
  localparam logic [15:0]      PRIOR_RESET = 16'd2560;
  localparam logic [7:0]       SCALE_RESET = 8'd32;

  localparam logic [0:0] REG_PRIOR = 1'b0;
  localparam logic [0:0] REG_SCALE = 1'b1;

  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/ucb1_bandit_selector_core.sv
// Select: accept and take the logarithm (skipped when the total is at most one), then
// per arm a read, a 41-step divider, a 21-step square root and a compare;
// an untried arm ends the scan at once, and the output state presents the result once any earlier result is taken.
// Observe reads the arm, runs the 41-step divider and writes back; set count and set
// mean read and write the arm; clear acts when accepted. One transaction is in work at a time.
// Reset is synchronous: control and configuration registers return to their defaults and
// every arm reads as unpulled with the prior mean; the arm memory is not swept.
module ucb1_bandit_selector_core #(
  parameter int NUM_ARMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  arm,
  input  logic signed [15:0] value,
  input  logic [23:0] count,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [3:0]  chosen_arm,
  output logic        untried_pick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(NUM_ARMS);
  localparam int WW = ucb1_pkg::CNT_W + ucb1_pkg::MEAN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_LN, S_NUM, S_ISSUE, S_EVAL, S_DIV, S_SQRT, S_CMP, S_OUT,
    S_MRD, S_MOD, S_MWR
  } state_t;

  state_t state;

  logic [15:0] prior;
  logic [7:0]  scale;
  logic [31:0] clear_mean;
  logic [31:0] total;
  logic [NUM_ARMS-1:0] vld;

  logic [WW-1:0] mem [NUM_ARMS];
  logic [WW-1:0] mem_q;
  logic          we;
  logic [WW-1:0] wdata;

  logic [AW-1:0] addr;
  logic [2:0]    op_q;
  logic [15:0]   val_q;
  logic [23:0]   cnt_q;

  logic [4:0]  lk;
  logic [31:0] ly;
  logic [15:0] lfrac;
  logic [4:0]  lcnt;
  logic [ucb1_pkg::LN_W-1:0]  lnq;
  logic [ucb1_pkg::NUM_W-1:0] num;

  logic [23:0] div_rem;
  logic [23:0] div_d;
  logic [ucb1_pkg::NUM_W-1:0] div_q;
  logic [5:0]  div_cnt;

  logic [ucb1_pkg::SQ_W-1:0] sq_rem;
  logic [ucb1_pkg::SQ_W-1:0] sq_res;
  logic [ucb1_pkg::SQ_W-1:0] sq_bit;
  logic [4:0]  sq_cnt;

  logic [23:0] n_q;
  logic signed [31:0] mean_q;
  logic        neg_q;
  logic signed [33:0] best;
  logic [AW-1:0] best_arm;
  logic [AW-1:0] res_arm;
  logic        res_untried;

  logic        accept;
  logic [23:0] cur_cnt;
  logic signed [31:0] cur_mean;
  logic [23:0] n_next;
  logic signed [32:0] diff;
  logic [32:0] diff_abs;
  logic [24:0] trial;
  logic        trial_ge;
  logic [ucb1_pkg::SQ_W:0] sq_sum;
  logic [63:0] sq_prod;
  logic [33:0] ly_sq;
  logic [52:0] ln_prod;
  logic signed [33:0] score;
  logic        take;
  logic signed [32:0] quot;
  logic [31:0] new_mean;
  logic [4:0]  tk;

  function automatic logic [24:0] value_sx(input logic [15:0] v);
    return {{9{v[15]}}, v};
  endfunction

  assign pready    = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign prdata    = (paddr[2] == ucb1_pkg::REG_SCALE) ? {24'b0, scale}
                                                       : {{16{prior[15]}}, prior};

  always_comb begin
    cur_cnt  = vld[addr] ? mem_q[WW-1:ucb1_pkg::MEAN_W] : '0;
    cur_mean = vld[addr] ? mem_q[ucb1_pkg::MEAN_W-1:0] : clear_mean;
    n_next   = (cur_cnt == ucb1_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 24'd1;
    diff     = {value_sx(val_q), 8'b0} - {cur_mean[31], cur_mean};
    diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    trial    = {div_rem, div_q[ucb1_pkg::NUM_W-1]};
    trial_ge = (trial >= {1'b0, div_d});
    sq_sum   = {1'b0, sq_res} + {1'b0, sq_bit};
    sq_prod  = ly * ly;
    ly_sq    = sq_prod[63:30];
    ln_prod  = {lk, lfrac} * ucb1_pkg::LN2_Q32;
    score    = 34'(mean_q) + 34'(sq_res);
    take     = (addr == '0) || (score > best);
    quot     = 33'(div_q[32:0]);
    new_mean = 32'(mean_q + (neg_q ? -quot : quot));
    tk       = ucb1_pkg::top_bit(total);
    we       = 1'b0;
    wdata    = {cur_cnt, cur_mean};
    if (state == S_MOD) begin
      if (op_q == ucb1_pkg::OP_SETCNT) begin
        we    = 1'b1;
        wdata = {cnt_q, cur_mean};
      end else if (op_q == ucb1_pkg::OP_SETMEAN) begin
        we    = 1'b1;
        wdata = {cur_cnt, {{8{val_q[15]}}, val_q, 8'b0}};
      end
    end else if (state == S_MWR) begin
      we    = 1'b1;
      wdata = {n_q, new_mean};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prior       <= ucb1_pkg::PRIOR_RESET;
      scale       <= ucb1_pkg::SCALE_RESET;
      clear_mean  <= {{8{ucb1_pkg::PRIOR_RESET[15]}}, ucb1_pkg::PRIOR_RESET, 8'b0};
      total       <= '0;
      vld         <= '0;
      rsp_valid   <= 1'b0;
      addr        <= '0;
      lcnt        <= '0;
      div_cnt     <= '0;
      sq_cnt      <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == ucb1_pkg::REG_SCALE) begin
          scale <= pwdata[7:0];
        end else begin
          prior <= pwdata[15:0];
        end
      end
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation;
            val_q <= value;
            cnt_q <= count;
            case (ucb1_pkg::op_t'(operation))
              ucb1_pkg::OP_SELECT: begin
                if (total > 32'd1) begin
                  lk    <= tk;
                  ly    <= (tk <= 5'd30) ? 32'(total << (5'd30 - tk)) : total >> 1;
                  lfrac <= '0;
                  lcnt  <= 5'd16;
                  state <= S_LOG;
                end else begin
                  lnq   <= '0;
                  state <= S_NUM;
                end
              end
              ucb1_pkg::OP_OBSERVE, ucb1_pkg::OP_SETCNT, ucb1_pkg::OP_SETMEAN: begin
                if (32'(arm) < NUM_ARMS) begin
                  addr  <= AW'(arm);
                  state <= S_MRD;
                end
              end
              ucb1_pkg::OP_CLEAR: begin
                vld        <= '0;
                total      <= '0;
                clear_mean <= {{8{prior[15]}}, prior, 8'b0};
              end
              default: begin
              end
            endcase
          end
        end
        S_LOG: begin
          if (lcnt == '0) begin
            state <= S_LN;
          end else begin
            lcnt <= lcnt - 5'd1;
            if (ly_sq >= 34'h80000000) begin
              ly    <= ly_sq[32:1];
              lfrac <= {lfrac[14:0], 1'b1};
            end else begin
              ly    <= ly_sq[31:0];
              lfrac <= {lfrac[14:0], 1'b0};
            end
          end
        end
        S_LN: begin
          lnq   <= ln_prod[52:32];
          state <= S_NUM;
        end
        S_NUM: begin
          num   <= {29'(scale * lnq), 12'b0};
          addr  <= '0;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur_cnt == '0) begin
            res_arm     <= addr;
            res_untried <= 1'b1;
            state       <= S_OUT;
          end else begin
            mean_q  <= cur_mean;
            div_rem <= '0;
            div_d   <= cur_cnt;
            div_q   <= num;
            div_cnt <= 6'(ucb1_pkg::NUM_W);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            if (op_q == ucb1_pkg::OP_SELECT) begin
              sq_rem <= ucb1_pkg::SQ_W'(div_q);
              sq_res <= '0;
              sq_bit <= ucb1_pkg::SQ_W'(1) << (ucb1_pkg::SQ_W - 2);
              sq_cnt <= 5'(ucb1_pkg::SQ_W / 2);
              state  <= S_SQRT;
            end else begin
              state <= S_MWR;
            end
          end else begin
            div_cnt <= div_cnt - 6'd1;
            div_rem <= trial_ge ? 24'(trial - {1'b0, div_d}) : trial[23:0];
            div_q   <= {div_q[ucb1_pkg::NUM_W-2:0], trial_ge};
          end
        end
        S_SQRT: begin
          if (sq_cnt == '0) begin
            state <= S_CMP;
          end else begin
            sq_cnt <= sq_cnt - 5'd1;
            if ({1'b0, sq_rem} >= sq_sum) begin
              sq_rem <= ucb1_pkg::SQ_W'({1'b0, sq_rem} - sq_sum);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_CMP: begin
          if (take) begin
            best     <= score;
            best_arm <= addr;
          end
          if (32'(addr) == NUM_ARMS - 1) begin
            res_arm     <= take ? addr : best_arm;
            res_untried <= 1'b0;
            state       <= S_OUT;
          end else begin
            addr  <= addr + AW'(1);
            state <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            chosen_arm   <= 4'(res_arm);
            untried_pick <= res_untried;
            state        <= S_IDLE;
          end
        end
        S_MRD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (op_q == ucb1_pkg::OP_OBSERVE) begin
            n_q     <= n_next;
            mean_q  <= cur_mean;
            neg_q   <= diff[32];
            div_rem <= '0;
            div_d   <= n_next;
            div_q   <= ucb1_pkg::NUM_W'(diff_abs);
            div_cnt <= 6'(ucb1_pkg::NUM_W);
            state   <= S_DIV;
          end else begin
            vld[addr] <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_MWR: begin
          vld[addr] <= 1'b1;
          if (total != ucb1_pkg::TOTAL_MAX) begin
            total <= total + 32'd1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && operation == ucb1_pkg::OP_CLEAR |=> total == '0 && vld == '0)
    else $error("clear did not empty the arm state");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt <= 6'(ucb1_pkg::NUM_W))
    else $error("divider step count out of range");

  a_sqrt_width: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> sq_res < (ucb1_pkg::SQ_W'(1) << (ucb1_pkg::SQ_W / 2)))
    else $error("square root result too wide");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    accept && operation == ucb1_pkg::OP_SELECT |=> req_stall)
    else $error("select did not hold off the next transaction");
`endif

endmodule

>>> test/tb_ucb1_bandit_selector_core.sv
module tb_ucb1_bandit_selector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARMS = 16;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  operation;
  logic [3:0]  arm;
  logic signed [15:0] value;
  logic [23:0] count;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [3:0]  chosen_arm;
  logic        untried_pick;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  typedef struct packed {
    logic [3:0] pick;
    logic       untried;
  } pick_t;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  a;
    logic [15:0] v;
    logic [23:0] c;
    logic        typed;
    pick_t       want;
  } row_t;

  logic signed [15:0] prior_q88;
  logic [7:0]         scale_q44;
  logic [23:0]        pulls [ARMS];
  logic signed [31:0] means [ARMS];
  logic [31:0]        total_obs;

  pick_t picks_due[$];
  int    mismatches;
  int    picks_seen;
  bit    stall_quiet;

  ucb1_bandit_selector_core #(.NUM_ARMS(ARMS)) u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] log2_fixed(input logic [31:0] t);
    int k;
    logic [63:0] y;
    logic [31:0] frac;
    k = 31;
    frac = '0;
    while (k > 0 && !t[k]) k--;
    if (k <= 30) y = 64'(t) << (30 - k);
    else y = 64'(t) >> 1;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return (32'(k) << 16) | frac;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void wipe_arms();
    for (int i = 0; i < ARMS; i++) begin
      pulls[i] = '0;
      means[i] = 32'(prior_q88) <<< 8;
    end
    total_obs = '0;
  endfunction

  function automatic bit apply_item(input logic [2:0] op, input logic [3:0] a,
                                    input logic [15:0] v, input logic [23:0] c,
                                    output pick_t p);
    logic signed [31:0] val;
    logic [63:0] ln_q, num, bonus;
    logic signed [63:0] score, best_score, diff;
    logic [23:0] n;
    val = 32'(signed'(v)) <<< 8;
    p = '0;
    case (op)
      ucb1_pkg::OP_SELECT: begin
        for (int i = 0; i < ARMS; i++) begin
          if (pulls[i] == 0) begin
            p.pick = 4'(i);
            p.untried = 1'b1;
            return 1;
          end
        end
        ln_q = '0;
        if (total_obs > 1)
          ln_q = (64'(log2_fixed(total_obs)) * 64'(ucb1_pkg::LN2_Q32)) >> 32;
        best_score = '0;
        for (int i = 0; i < ARMS; i++) begin
          num = (64'(scale_q44) * ln_q) << 12;
          bonus = int_sqrt(num / 64'(pulls[i]));
          score = 64'(means[i]) + signed'(bonus);
          if (i == 0 || score > best_score) begin
            best_score = score;
            p.pick = 4'(i);
          end
        end
        return 1;
      end
      ucb1_pkg::OP_CLEAR: wipe_arms();
      ucb1_pkg::OP_OBSERVE: begin
        n = pulls[a];
        if (n != ucb1_pkg::COUNT_MAX) n = n + 1;
        pulls[a] = n;
        diff = 64'(val) - 64'(means[a]);
        means[a] = 32'(64'(means[a]) + diff / signed'(64'(n)));
        if (total_obs != ucb1_pkg::TOTAL_MAX) total_obs = total_obs + 1;
      end
      ucb1_pkg::OP_SETCNT: pulls[a] = c;
      ucb1_pkg::OP_SETMEAN: means[a] = val;
      default: ;
    endcase
    return 0;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(ucb1_pkg::REG_PRIOR) << 2) prior_q88 = data[15:0];
    else scale_q44 = data[7:0];
    @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic send(input logic [2:0] op, input logic [3:0] a, input logic [15:0] v,
                      input logic [23:0] c, input bit typed, input pick_t want);
    pick_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    arm <= a;
    value <= v;
    count <= c;
    do @(posedge clk); while (req_stall);
    if (apply_item(op, a, v, c, p)) begin
      if (typed && p != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: table row expects %h, predictor gives %h", want, p);
      end
      picks_due.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      picks_seen++;
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: arm %0d", chosen_arm);
      end else begin
        pick_t w;
        w = picks_due.pop_front();
        if (chosen_arm !== w.pick || untried_pick !== w.untried) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected arm %0d untried %0b, got arm %0d untried %0b",
                     w.pick, w.untried, chosen_arm, untried_pick);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || stall_quiet) rsp_stall <= 1'b0;
    else if ($urandom_range(0, 15) == 0) rsp_stall <= 1'b1;
    else if (rsp_stall && $urandom_range(0, 3) != 0) rsp_stall <= 1'b1;
    else rsp_stall <= 1'b0;
  end

  task automatic run_random(input int items);
    logic [2:0] op;
    logic [3:0] a;
    logic [15:0] v;
    logic [23:0] c;
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = ucb1_pkg::OP_SELECT;
      else if (r < 70) op = ucb1_pkg::OP_OBSERVE;
      else if (r < 82) op = ucb1_pkg::OP_SETCNT;
      else if (r < 92) op = ucb1_pkg::OP_SETMEAN;
      else if (r < 96) op = ucb1_pkg::OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      a = 4'($urandom);
      v = 16'($urandom);
      r = $urandom_range(0, 9);
      if (r < 6) c = 24'($urandom_range(0, 40));
      else if (r < 8) c = 24'($urandom);
      else c = ucb1_pkg::COUNT_MAX - 24'($urandom_range(0, 2));
      send(op, a, v, c, 1'b0, '0);
    end
  endtask

  row_t rows [$];

  initial begin
    pick_t none;
    none = '0;
    rst = 1'b1;
    req_valid = 1'b0;
    operation = '0;
    arm = '0;
    value = '0;
    count = '0;
    rsp_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    picks_seen = 0;
    stall_quiet = 1'b0;
    prior_q88 = ucb1_pkg::PRIOR_RESET;
    scale_q44 = ucb1_pkg::SCALE_RESET;
    wipe_arms();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{ucb1_pkg::OP_SELECT, 4'd0, 16'h0000, 24'd0, 1'b1, '{4'd0, 1'b1}},
      '{ucb1_pkg::OP_OBSERVE, 4'd0, 16'h7FFF, 24'd0, 1'b0, none},
      '{ucb1_pkg::OP_SELECT, 4'd0, 16'h0000, 24'd0, 1'b1, '{4'd1, 1'b1}},
      '{ucb1_pkg::OP_SETCNT, 4'd15, 16'h0000, 24'hFFFFFF, 1'b0, none},
      '{ucb1_pkg::OP_SETMEAN, 4'd15, 16'h8000, 24'd0, 1'b0, none},
      '{ucb1_pkg::OP_OBSERVE, 4'd15, 16'h8000, 24'd0, 1'b0, none},
      '{3'd5, 4'd1, 16'h1234, 24'd5, 1'b0, none},
      '{3'd7, 4'd2, 16'hFFFF, 24'd9, 1'b0, none},
      '{ucb1_pkg::OP_SELECT, 4'd0, 16'h0000, 24'd0, 1'b1, '{4'd1, 1'b1}},
      '{ucb1_pkg::OP_SETCNT, 4'd1, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd2, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd3, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd4, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd5, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd6, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd7, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd8, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd9, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd10, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd11, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd12, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd13, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SETCNT, 4'd14, 16'h0, 24'd1, 1'b0, none},
      '{ucb1_pkg::OP_SELECT, 4'd0, 16'h0000, 24'd0, 1'b0, none},
      '{ucb1_pkg::OP_CLEAR, 4'd0, 16'h0000, 24'd0, 1'b0, none}
    };
    foreach (rows[i])
      send(rows[i].op, rows[i].a, rows[i].v, rows[i].c, rows[i].typed, rows[i].want);

    run_random(250);
    settle();
    write_reg(3'(ucb1_pkg::REG_PRIOR) << 2, 32'h0000_8000);
    write_reg(3'(ucb1_pkg::REG_SCALE) << 2, 32'h0000_00FF);
    send(ucb1_pkg::OP_CLEAR, 4'd0, 16'h0, 24'd0, 1'b0, none);
    run_random(300);
    settle();
    write_reg(3'(ucb1_pkg::REG_PRIOR) << 2, 32'h0000_7FFF);
    write_reg(3'(ucb1_pkg::REG_SCALE) << 2, 32'h0000_0000);
    send(ucb1_pkg::OP_CLEAR, 4'd0, 16'h0, 24'd0, 1'b0, none);
    stall_quiet = 1'b1;
    run_random(300);
    stall_quiet = 1'b0;
    settle();
    write_reg(3'(ucb1_pkg::REG_PRIOR) << 2, 32'($urandom));
    write_reg(3'(ucb1_pkg::REG_SCALE) << 2, 32'($urandom));
    send(ucb1_pkg::OP_CLEAR, 4'd0, 16'h0, 24'd0, 1'b0, none);
    run_random(650);
    settle();

    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ucb1_pkg.sv
rtl/ucb1_bandit_selector_core.sv
test/tb_ucb1_bandit_selector_core.sv
